FILE: rtl/core/i2cms_pkg.sv
// Shared command codes and line/data state type for the I2C bit sequencer.
package i2cms_pkg;

  localparam logic [2:0] FUNC_START    = 3'd0;
  localparam logic [2:0] FUNC_STOP     = 3'd1;
  localparam logic [2:0] FUNC_SEND     = 3'd2;
  localparam logic [2:0] FUNC_READ     = 3'd3;
  localparam logic [2:0] FUNC_WAIT_ACK = 3'd4;
  localparam logic [2:0] FUNC_ACK      = 3'd5;
  localparam logic [2:0] FUNC_NACK     = 3'd6;
  localparam logic [2:0] FUNC_LAST     = FUNC_NACK;

  localparam int unsigned PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] LAST_BIT = 4'd7;
  localparam logic [3:0] STEP_MAX = 4'd15;

  // Line drive levels plus the data held across phases.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
    logic       ack;
    logic [7:0] rx;
  } line_state_t;

endpackage

FILE: rtl/core/i2cms_phase.sv
// Combinational actions of one command phase: line levels, shifting, sampling.
module i2cms_phase (
  input  logic [2:0]            cmd,
  input  logic [3:0]            phase,
  input  logic [3:0]            bit_idx,
  input  logic                  sda_in,
  input  i2cms_pkg::line_state_t st_in,
  output i2cms_pkg::line_state_t st_out,
  output logic                  finish
);
  import i2cms_pkg::*;

  always_comb begin
    st_out = st_in;
    finish = 1'b0;
    unique case (cmd)
      FUNC_START: begin
        priority if (phase == 4'd0) begin
          st_out.scl = 1'b1;
          st_out.sda = 1'b1;
        end else if (phase == 4'd1) begin
          st_out.sda = 1'b0;
        end else if (phase == 4'd2) begin
          st_out.scl = 1'b0;
        end else begin
          finish = 1'b1;
        end
      end
      FUNC_STOP: begin
        if (phase == 4'd0) begin
          st_out.sda = 1'b0;
          st_out.scl = 1'b1;
        end else begin
          st_out.sda = 1'b1;
          finish     = 1'b1;
        end
      end
      FUNC_SEND: begin
        priority if (bit_idx >= BITS_PER_BYTE) begin
          finish = 1'b1;
        end else if (phase == 4'd0) begin
          st_out.sda = st_in.shift[7];
        end else if (phase == 4'd1) begin
          st_out.scl = 1'b1;
        end else begin
          st_out.scl   = 1'b0;
          // release SDA for the ack slot after the last data bit
          if (bit_idx == LAST_BIT) st_out.sda = 1'b1;
          st_out.shift = {st_in.shift[6:0], 1'b0};
        end
      end
      FUNC_READ: begin
        priority if (bit_idx >= BITS_PER_BYTE) begin
          st_out.rx = st_in.shift;
          finish    = 1'b1;
        end else if (phase == 4'd0) begin
          st_out.scl = 1'b1;
        end else begin
          st_out.shift = {st_in.shift[6:0], sda_in};
          st_out.scl   = 1'b0;
        end
      end
      FUNC_WAIT_ACK: begin
        priority if (phase == 4'd0) begin
          st_out.sda = 1'b1;
        end else if (phase == 4'd1) begin
          st_out.scl = 1'b1;
        end else if (phase == 4'd2) begin
          st_out.ack = sda_in;
          st_out.scl = 1'b0;
        end else begin
          finish = 1'b1;
        end
      end
      FUNC_ACK: begin
        priority if (phase == 4'd0) begin
          st_out.sda = 1'b0;
        end else if (phase == 4'd1) begin
          st_out.scl = 1'b1;
        end else if (phase == 4'd2) begin
          st_out.scl = 1'b0;
        end else begin
          st_out.sda = 1'b1;
          finish     = 1'b1;
        end
      end
      default: begin
        // nack
        priority if (phase == 4'd0) begin
          st_out.sda = 1'b1;
        end else if (phase == 4'd1) begin
          st_out.scl = 1'b1;
        end else if (phase == 4'd2) begin
          st_out.scl = 1'b0;
        end else begin
          finish = 1'b1;
        end
      end
    endcase
  end

endmodule

FILE: rtl/core/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: tick-driven command phases, one result beat per tick beat.
// Each input beat is one timer tick and produces exactly one result beat. A beat
// is taken every clock cycle as long as the result register is empty or being
// drained; its result appears in the next cycle. The state update and the result
// are computed in a single pass of logic ahead of that one result register.
// Every phase holds its line levels for half_period ticks (zero counts as
// one); commands offered while a command is running are dropped.
module i2c_master_bit_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [i2cms_pkg::PERIOD_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd_valid,
  input  logic [2:0]                     func,
  input  logic [7:0]                     tx_byte,
  input  logic                           sda_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           scl_level,
  output logic                           sda_level,
  output logic                           ready_res,
  output logic                           done_res,
  output logic [7:0]                     rx_byte,
  output logic                           nack_seen
);
  import i2cms_pkg::*;

  logic [PERIOD_W-1:0] half_period;
  logic                busy;
  logic [2:0]          cmd;
  logic [3:0]          phase;
  logic [3:0]          bit_idx;
  logic [PERIOD_W-1:0] delay;
  line_state_t         st;

  logic                busy_next;
  logic [2:0]          cmd_next;
  logic [3:0]          phase_next;
  logic [3:0]          bit_idx_next;
  logic [PERIOD_W-1:0] delay_next;
  line_state_t         st_next;
  logic                done_next;

  logic                accept;
  logic [PERIOD_W-1:0] period;
  logic [3:0]          phase_adv;
  logic [3:0]          bit_adv;
  logic [2:0]          pm_cmd;
  logic [3:0]          pm_phase;
  logic [3:0]          pm_bit;
  line_state_t         pm_st_in;
  line_state_t         pm_st_out;
  logic                pm_finish;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign period   = (half_period == '0) ? PERIOD_W'(1) : half_period;

  // Step to the next phase; send and read loop their per-bit phases.
  always_comb begin
    phase_adv = phase;
    bit_adv   = bit_idx;
    priority if ((cmd == FUNC_SEND && phase >= 4'd2) ||
                 (cmd == FUNC_READ && phase >= 4'd1)) begin
      phase_adv = '0;
      if (bit_idx < STEP_MAX) bit_adv = bit_idx + 4'd1;
    end else if (phase < STEP_MAX) begin
      phase_adv = phase + 4'd1;
    end
  end

  always_comb begin
    pm_cmd   = busy ? cmd : func;
    pm_phase = busy ? phase_adv : 4'd0;
    pm_bit   = busy ? bit_adv : 4'd0;
    pm_st_in = st;
    if (!busy) pm_st_in.shift = (func == FUNC_SEND) ? tx_byte : 8'd0;
  end

  i2cms_phase u_phase (
    .cmd     (pm_cmd),
    .phase   (pm_phase),
    .bit_idx (pm_bit),
    .sda_in  (sda_in),
    .st_in   (pm_st_in),
    .st_out  (pm_st_out),
    .finish  (pm_finish)
  );

  always_comb begin
    busy_next    = busy;
    cmd_next     = cmd;
    phase_next   = phase;
    bit_idx_next = bit_idx;
    delay_next   = delay;
    st_next      = st;
    done_next    = 1'b0;
    if (busy) begin
      if (delay > PERIOD_W'(1)) begin
        delay_next = delay - PERIOD_W'(1);
      end else begin
        phase_next   = phase_adv;
        bit_idx_next = bit_adv;
        st_next      = pm_st_out;
        if (pm_finish) begin
          busy_next  = 1'b0;
          delay_next = '0;
          done_next  = 1'b1;
        end else begin
          delay_next = period;
        end
      end
    end else if (cmd_valid && func <= FUNC_LAST) begin
      cmd_next     = func;
      phase_next   = '0;
      bit_idx_next = '0;
      busy_next    = 1'b1;
      delay_next   = period;
      st_next      = pm_st_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cmd       <= '0;
      phase     <= '0;
      bit_idx   <= '0;
      delay     <= '0;
      st.scl    <= 1'b1;
      st.sda    <= 1'b1;
      st.shift  <= '0;
      st.ack    <= 1'b0;
      st.rx     <= '0;
    end else if (accept) begin
      busy    <= busy_next;
      cmd     <= cmd_next;
      phase   <= phase_next;
      bit_idx <= bit_idx_next;
      delay   <= delay_next;
      st      <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_level <= st_next.scl;
      sda_level <= st_next.sda;
      ready_res <= !busy_next;
      done_res  <= done_next;
      rx_byte   <= st_next.rx;
      nack_seen <= st_next.ack;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the tick-driven I2C master bit sequencer.
module testbench;
  import i2cms_pkg::*;

  localparam int CLOCK_LIMIT     = 1_000_000;
  localparam int RANDOM_TICKS    = 1400;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int SETTLE_CYCLES   = 4;
  localparam logic [2:0] FUNC_UNUSED = 3'd7;

  typedef enum {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_drive_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       ready;
    logic       done;
    logic [7:0] rx;
    logic       nack;
  } tick_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [PERIOD_W-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                cmd_valid = 1'b0;
  logic [2:0]          func = FUNC_START;
  logic [7:0]          tx_byte = 8'h00;
  logic                sda_in = 1'b1;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                scl_level;
  logic                sda_level;
  logic                ready_res;
  logic                done_res;
  logic [7:0]          rx_byte;
  logic                nack_seen;

  i2c_master_bit_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_valid (cmd_valid),
    .func      (func),
    .tx_byte   (tx_byte),
    .sda_in    (sda_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .ready_res (ready_res),
    .done_res  (done_res),
    .rx_byte   (rx_byte),
    .nack_seen (nack_seen)
  );

  // Sequencer state as tracked by the predictor.
  logic [2:0]          seq_cmd = FUNC_START;
  logic                seq_busy = 1'b0;
  logic [3:0]          seq_step = 4'd0;
  logic [PERIOD_W-1:0] seq_delay = '0;
  logic [3:0]          seq_bit = 4'd0;
  logic [7:0]          seq_shift = 8'h00;
  logic                seq_scl = 1'b1;
  logic                seq_sda = 1'b1;
  logic                seq_ack = 1'b0;
  logic [7:0]          seq_rx = 8'h00;
  logic [PERIOD_W-1:0] seq_period = PERIOD_RESET;

  tick_result_t expected_lines[$];

  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  int errors = 0;
  int ticks_sent = 0;
  int cmds_offered = 0;
  int cmds_done = 0;
  int results_checked = 0;
  int periods_written = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CLOCK_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               expected_lines.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [PERIOD_W-1:0] phase_ticks();
    return (seq_period == '0) ? 16'd1 : seq_period;
  endfunction

  // Line actions of the current phase; returns 1 when the command is over.
  function automatic bit apply_phase(logic sda);
    case (seq_cmd)
      FUNC_START: begin
        if (seq_step == 0) begin seq_scl = 1'b1; seq_sda = 1'b1; end
        else if (seq_step == 1) seq_sda = 1'b0;
        else if (seq_step == 2) seq_scl = 1'b0;
        else return 1'b1;
        return 1'b0;
      end
      FUNC_STOP: begin
        if (seq_step == 0) begin
          seq_sda = 1'b0;
          seq_scl = 1'b1;
          return 1'b0;
        end
        seq_sda = 1'b1;
        return 1'b1;
      end
      FUNC_SEND: begin
        if (seq_bit >= BITS_PER_BYTE) return 1'b1;
        if (seq_step == 0) seq_sda = seq_shift[7];
        else if (seq_step == 1) seq_scl = 1'b1;
        else begin
          seq_scl = 1'b0;
          // release SDA after the last data bit so the slave can ack
          if (seq_bit == LAST_BIT) seq_sda = 1'b1;
          seq_shift = {seq_shift[6:0], 1'b0};
        end
        return 1'b0;
      end
      FUNC_READ: begin
        if (seq_bit >= BITS_PER_BYTE) begin
          seq_rx = seq_shift;
          return 1'b1;
        end
        if (seq_step == 0) seq_scl = 1'b1;
        else begin
          seq_shift = {seq_shift[6:0], sda};
          seq_scl = 1'b0;
        end
        return 1'b0;
      end
      FUNC_WAIT_ACK: begin
        if (seq_step == 0) seq_sda = 1'b1;
        else if (seq_step == 1) seq_scl = 1'b1;
        else if (seq_step == 2) begin seq_ack = sda; seq_scl = 1'b0; end
        else return 1'b1;
        return 1'b0;
      end
      FUNC_ACK: begin
        if (seq_step == 0) seq_sda = 1'b0;
        else if (seq_step == 1) seq_scl = 1'b1;
        else if (seq_step == 2) seq_scl = 1'b0;
        else begin
          seq_sda = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (seq_step == 0) seq_sda = 1'b1;
        else if (seq_step == 1) seq_scl = 1'b1;
        else if (seq_step == 2) seq_scl = 1'b0;
        else return 1'b1;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic tick_result_t predict_tick(logic valid, logic [2:0] f, logic [7:0] tx,
                                                logic sda);
    tick_result_t r;
    logic done;
    done = 1'b0;
    if (seq_busy) begin
      if (seq_delay > 1) seq_delay = seq_delay - 1'b1;
      else begin
        // byte commands loop over bits, the rest just step through phases
        if (seq_cmd == FUNC_SEND && seq_step >= 2) begin
          seq_step = 4'd0;
          if (seq_bit < STEP_MAX) seq_bit = seq_bit + 1'b1;
        end else if (seq_cmd == FUNC_READ && seq_step >= 1) begin
          seq_step = 4'd0;
          if (seq_bit < STEP_MAX) seq_bit = seq_bit + 1'b1;
        end else if (seq_step < STEP_MAX) begin
          seq_step = seq_step + 1'b1;
        end
        if (apply_phase(sda)) begin
          seq_busy = 1'b0;
          seq_delay = '0;
          done = 1'b1;
        end else begin
          seq_delay = phase_ticks();
        end
      end
    end else if (valid && f <= FUNC_LAST) begin
      seq_cmd = f;
      seq_step = 4'd0;
      seq_bit = 4'd0;
      seq_shift = (f == FUNC_SEND) ? tx : 8'h00;
      seq_busy = 1'b1;
      seq_delay = phase_ticks();
      void'(apply_phase(sda));
    end
    r.scl = seq_scl;
    r.sda = seq_sda;
    r.ready = ~seq_busy;
    r.done = done;
    r.rx = seq_rx;
    r.nack = seq_ack;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d (cycle %0d)",
             results_checked, what, got, want, cycles);
    errors++;
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("result beat with nothing expected", 1, 0);
      end else begin
        want = expected_lines.pop_front();
        check_field("scl_level", scl_level, want.scl);
        check_field("sda_level", sda_level, want.sda);
        check_field("ready_res", ready_res, want.ready);
        check_field("done_res", done_res, want.done);
        check_field("rx_byte", rx_byte, want.rx);
        check_field("nack_seen", nack_seen, want.nack);
        if (want.done) cmds_done++;
        results_checked++;
      end
    end
  end

  // Result side: random stalls per beat, plus a long hold-off on request.
  initial begin
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (rst) out_ready <= 1'b0;
      else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if (out_valid && out_ready) rx_wait = idle_on ? $urandom_range(0, 3) : 0;
        if (rx_wait > 0) begin
          out_ready <= 1'b0;
          rx_wait--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  function automatic logic pick_sda(sda_drive_t mode);
    case (mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return logic'($urandom_range(0, 1));
    endcase
  endfunction

  // One tick beat; in_valid stays up across back-to-back beats.
  task automatic send_tick(logic valid, logic [2:0] f, logic [7:0] tx, logic sda);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_valid <= valid;
    func <= f;
    tx_byte <= tx;
    sda_in <= sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_lines.push_back(predict_tick(valid, f, tx, sda));
    ticks_sent++;
    if (valid) cmds_offered++;
  endtask

  // Offer a command, then tick until the sequencer is idle again.
  task automatic run_command(logic [2:0] f, logic [7:0] tx, sda_drive_t mode, bit busy_noise);
    send_tick(1'b1, f, tx, pick_sda(mode));
    while (seq_busy) begin
      send_tick(busy_noise ? logic'($urandom_range(0, 1)) : 1'b0,
                3'($urandom_range(0, 7)), 8'($urandom), pick_sda(mode));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    cmd_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    seq_period = value;
    periods_written++;
  endtask

  task automatic test_reset_period();
    run_command(FUNC_START, 8'h00, SDA_RANDOM, 1'b0);
    run_command(FUNC_STOP, 8'h00, SDA_RANDOM, 1'b0);
  endtask

  task automatic test_zero_period_commands();
    write_period('0);
    run_command(FUNC_START, 8'h00, SDA_RANDOM, 1'b0);
    run_command(FUNC_SEND, 8'hFF, SDA_RANDOM, 1'b0);
    run_command(FUNC_SEND, 8'h00, SDA_RANDOM, 1'b0);
    run_command(FUNC_WAIT_ACK, 8'h00, SDA_LOW, 1'b0);
    run_command(FUNC_WAIT_ACK, 8'h00, SDA_HIGH, 1'b0);
    run_command(FUNC_READ, 8'h00, SDA_HIGH, 1'b0);
    run_command(FUNC_READ, 8'h00, SDA_LOW, 1'b0);
    run_command(FUNC_READ, 8'h00, SDA_RANDOM, 1'b0);
    run_command(FUNC_ACK, 8'h00, SDA_RANDOM, 1'b0);
    run_command(FUNC_NACK, 8'h00, SDA_RANDOM, 1'b0);
    run_command(FUNC_STOP, 8'h00, SDA_RANDOM, 1'b0);
  endtask

  task automatic test_busy_and_illegal();
    write_period(16'd1);
    run_command(FUNC_UNUSED, 8'h5A, SDA_RANDOM, 1'b0);
    run_command(FUNC_SEND, 8'hA5, SDA_RANDOM, 1'b1);
    run_command(FUNC_READ, 8'h00, SDA_RANDOM, 1'b1);
    run_command(FUNC_WAIT_ACK, 8'h00, SDA_RANDOM, 1'b1);
  endtask

  // Long period: load it into the delay counter, then drop to one tick
  // so the rest of the start finishes quickly.
  task automatic test_long_period();
    idle_on = 1'b0;
    write_period(16'd200);
    send_tick(1'b1, FUNC_START, 8'h00, 1'b1);
    write_period(16'd1);
    while (seq_busy) send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                               logic'($urandom_range(0, 1)));
    idle_on = 1'b1;
  endtask

  task automatic test_input_backpressure();
    write_period(16'd2);
    hold_request = 1'b1;
    run_command(FUNC_SEND, 8'($urandom), SDA_RANDOM, 1'b0);
    run_command(FUNC_WAIT_ACK, 8'h00, SDA_RANDOM, 1'b0);
  endtask

  task automatic test_random_transactions();
    int base;
    int pick;
    int nbytes;
    logic [PERIOD_W-1:0] periods[6];
    bit noise;
    periods = '{16'd0, 16'd1, 16'd1, 16'd2, 16'd3, 16'd5};
    base = ticks_sent;
    while (ticks_sent - base < RANDOM_TICKS) begin
      if ($urandom_range(0, 7) == 0) write_period(periods[$urandom_range(0, 5)]);
      idle_on = ($urandom_range(0, 4) != 0);
      noise = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // well-formed transfer: start, address, data bytes, stop
        run_command(FUNC_START, 8'($urandom), SDA_RANDOM, noise);
        run_command(FUNC_SEND, 8'($urandom), SDA_RANDOM, noise);
        run_command(FUNC_WAIT_ACK, 8'($urandom), SDA_RANDOM, noise);
        nbytes = $urandom_range(0, 3);
        repeat (nbytes) begin
          if ($urandom_range(0, 1)) begin
            run_command(FUNC_SEND, 8'($urandom), SDA_RANDOM, noise);
            run_command(FUNC_WAIT_ACK, 8'($urandom), SDA_RANDOM, noise);
          end else begin
            run_command(FUNC_READ, 8'($urandom), SDA_RANDOM, noise);
            run_command($urandom_range(0, 1) ? FUNC_ACK : FUNC_NACK, 8'($urandom),
                        SDA_RANDOM, noise);
          end
        end
        run_command(FUNC_STOP, 8'($urandom), SDA_RANDOM, noise);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_tick(logic'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 8'($urandom),
                    logic'($urandom_range(0, 1)));
        end
        while (seq_busy) send_tick(logic'(noise), 3'($urandom_range(0, 7)), 8'($urandom),
                                   logic'($urandom_range(0, 1)));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_period();
    test_zero_period_commands();
    test_busy_and_illegal();
    test_long_period();
    test_input_backpressure();
    test_random_transactions();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d tick beats, %0d commands offered, %0d finished, %0d results checked",
             ticks_sent, cmds_offered, cmds_done, results_checked);
    $display("half period rewritten %0d times (zero, one and a long one among them), %0d errors",
             periods_written, errors);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
